// ----- rtl/char_transliterate_squash_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the transliterator block.
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_TRANSLITERATE_SQUASH_TOP_ASSERT_SVH
`define CHAR_TRANSLITERATE_SQUASH_TOP_ASSERT_SVH

// Same-cycle implication check.
`define CTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants for the byte transliterator: table size, field widths,
// item mode codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

  // Table geometry
  localparam int unsigned SetSize = 64;
  localparam int unsigned IdxW    = $clog2(SetSize);
  localparam int unsigned LenW    = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ModeW   = 2;

  // Item mode codes
  localparam logic [ModeW-1:0] ModeLoadFrom = 2'd0;
  localparam logic [ModeW-1:0] ModeLoadTo   = 2'd1;
  localparam logic [ModeW-1:0] ModeData     = 2'd2;

  // Register indexes
  localparam logic [1:0] RegNegate  = 2'd0;
  localparam logic [1:0] RegFromLen = 2'd1;
  localparam logic [1:0] RegToLen   = 2'd2;

  // Clamp a length register to the table size
  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] n);
    logic [LenW-1:0] lim;
    lim = LenW'(SetSize);
    return (n > lim) ? lim : n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/char_transliterate_squash_top.sv -----
// ----------------------------------------------------------------------------
// char_transliterate_squash_top
// Byte-stream transliterator with from-set / to-set tables and squashing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word of mode,
//   entry_index and byte_value. Load words write the from-set or to-set
//   table in the cycle they are taken and give no result. Data words are
//   matched against the from-set by a scan that reads one from-set entry
//   per cycle from a synchronous memory; a replacement is read from to_mem.
//   Output channel (out_valid_o / out_stall_i) carries out_byte; a data
//   word gives zero or one output word.
//   A data word's time from acceptance to the output register is set by
//   the scan over the from-set memory, which ends early on a match.
//   The block takes the next word while a finished result sits in the
//   output register. When the receiver stalls, the output word holds and
//   a following data result waits in the block with in_stall_o high.
//   Reset clears the config registers, the run flag and the output valid.
//   Table contents are undefined until loaded. Registers are written over
//   the APB port (negate at 0x0, from length at 0x4, to length at 0x8).
// ----------------------------------------------------------------------------
`default_nettype none

module char_transliterate_squash_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [cts_pkg::ModeW-1:0]    mode_i,
  input  wire logic [cts_pkg::IdxW-1:0]     entry_index_i,
  input  wire logic [cts_pkg::ByteW-1:0]    byte_value_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [cts_pkg::ByteW-1:0]         out_byte_o,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [3:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  `include "char_transliterate_squash_top_assert.svh"

  localparam int unsigned IdxW  = cts_pkg::IdxW;
  localparam int unsigned LenW  = cts_pkg::LenW;
  localparam int unsigned ByteW = cts_pkg::ByteW;

  // State codes
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StScan    = 3'd1;
  localparam logic [2:0] StResolve = 3'd2;
  localparam logic [2:0] StTread   = 3'd3;
  localparam logic [2:0] StOut     = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             negate_q;
  logic [LenW-1:0]  from_len_q, to_len_q;
  logic             run_q, run_d;
  logic [LenW-1:0]  scan_cnt_q, scan_cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic [ByteW-1:0] res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;

  logic [ByteW-1:0] from_mem [cts_pkg::SetSize];
  logic [ByteW-1:0] to_mem   [cts_pkg::SetSize];
  logic [ByteW-1:0] from_rdata, to_rdata;
  logic [IdxW-1:0]  to_raddr;

  logic             in_acc, cfg_wr;
  logic [LenW-1:0]  flen, tlen, pos_eff;
  logic             hit, issue, squash_on, out_load;

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign flen   = cts_pkg::clamp_len(from_len_q);
  assign tlen   = cts_pkg::clamp_len(to_len_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      negate_q   <= 1'b0;
      from_len_q <= '0;
      to_len_q   <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        cts_pkg::RegNegate:  negate_q   <= pwdata[0];
        cts_pkg::RegFromLen: from_len_q <= pwdata[LenW-1:0];
        cts_pkg::RegToLen:   to_len_q   <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      cts_pkg::RegNegate:  prdata = {31'd0, negate_q};
      cts_pkg::RegFromLen: prdata = {{(32-LenW){1'b0}}, from_len_q};
      cts_pkg::RegToLen:   prdata = {{(32-LenW){1'b0}}, to_len_q};
      default:             prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Table memories: write on load words, registered read every cycle
  always_ff @(posedge clk_i) begin
    if (in_acc && mode_i == cts_pkg::ModeLoadFrom) begin
      from_mem[entry_index_i] <= byte_value_i;
    end
    from_rdata <= from_mem[scan_cnt_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && mode_i == cts_pkg::ModeLoadTo) begin
      to_mem[entry_index_i] <= byte_value_i;
    end
    to_rdata <= to_mem[to_raddr];
  end

  // Scan compare and position mapping
  assign hit     = cmp_vld_q && (from_rdata == byte_q);
  assign issue   = scan_cnt_q < flen;
  assign pos_eff = negate_q ? ((pos_q != '0) ? '0 : tlen + LenW'(1)) : pos_q;
  assign squash_on = (flen > tlen || negate_q) && (tlen != '0);
  assign out_load  = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    run_d      = run_q;
    scan_cnt_d = scan_cnt_q;
    cmp_vld_d  = 1'b0;
    pos_d      = pos_q;
    byte_d     = byte_q;
    res_d      = res_q;
    to_raddr   = '0;
    case (state_q)
      StIdle: begin
        if (in_acc && mode_i == cts_pkg::ModeData) begin
          byte_d     = byte_value_i;
          scan_cnt_d = '0;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (hit) begin
          pos_d   = scan_cnt_q;
          state_d = StResolve;
        end else if (!issue) begin
          pos_d   = '0;
          state_d = StResolve;
        end else begin
          scan_cnt_d = scan_cnt_q + LenW'(1);
          cmp_vld_d  = 1'b1;
        end
      end
      StResolve: begin
        if (squash_on && pos_eff >= tlen) begin
          if (run_q) begin
            state_d = StIdle;
          end else begin
            run_d    = 1'b1;
            to_raddr = IdxW'(tlen - LenW'(1));
            state_d  = StTread;
          end
        end else begin
          run_d = 1'b0;
          if (pos_eff == '0) begin
            res_d   = byte_q;
            state_d = StOut;
          end else if (pos_eff <= tlen) begin
            to_raddr = IdxW'(pos_eff - LenW'(1));
            state_d  = StTread;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StTread: begin
        res_d   = to_rdata;
        state_d = StOut;
      end
      StOut: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_byte_d  = res_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      run_q       <= 1'b0;
      scan_cnt_q  <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      scan_cnt_q  <= scan_cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    byte_q     <= byte_d;
    res_q      <= res_d;
    out_byte_q <= out_byte_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // Checks
  `CTS_ASSERT_IMP(a_scan_bound, state_q == StScan, scan_cnt_q <= flen,
                  "scan counter ran past from-set length")
  `CTS_ASSERT_NEXT(a_data_scan, in_acc && mode_i == cts_pkg::ModeData,
                   state_q == StScan, "data word did not start a scan")
  `CTS_ASSERT_NEXT(a_tread_out, state_q == StTread, state_q == StOut,
                   "to-set read not followed by output")
  `CTS_ASSERT_IMP(a_hit_pos, state_q == StScan && hit, scan_cnt_q != '0,
                  "match reported before any entry was read")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for char_transliterate_squash_top
// Drives load, data and unused words into the transliterator across a series
// of register settings (plain, negated, empty and oversized sets). It
// predicts every output byte, including squash runs, and compares each
// output word in order. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------

module tb;

  localparam logic [cts_pkg::ModeW-1:0] ModeUnused = 2'd3;
  localparam int SettleCycles = 80;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 900000;
  localparam int NumPhases    = 14;
  localparam int PhaseWords   = 90;
  localparam int NumRows      = 25;

  typedef enum logic [0:0] {RowItem, RowCfg} row_kind_e;
  typedef enum logic [1:0] {ExpPredict, ExpNone, ExpByte} exp_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] sel;    // mode for words, register index for writes
    logic [5:0] idx;
    logic [7:0] val;
    exp_kind_e  chk;
    logic [7:0] want;
  } dir_row_t;

  // Directed rows: reset behavior, table extremes, then each special case
  dir_row_t dir_rows [NumRows] = '{
    // empty sets after reset: every byte copies, unused mode is dropped
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h00, ExpByte, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd63, 8'hFF, ExpByte, 8'hFF},
    '{RowItem, ModeUnused,            6'd63, 8'hFF, ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeLoadFrom, 6'd0,  8'h61, ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeLoadFrom, 6'd1,  8'h00, ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeLoadFrom, 6'd63, 8'hFF, ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeLoadTo,   6'd0,  8'h58, ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeLoadTo,   6'd1,  8'hFF, ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeLoadTo,   6'd63, 8'h00, ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd5,  8'h61, ExpByte, 8'h61},
    // plain translation, equal set lengths
    '{RowCfg,  cts_pkg::RegFromLen,   6'd0,  8'd2,  ExpNone, 8'h00},
    '{RowCfg,  cts_pkg::RegToLen,     6'd0,  8'd2,  ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h61, ExpPredict, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h00, ExpPredict, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h62, ExpPredict, 8'h00},
    // empty to-set deletes matches
    '{RowCfg,  cts_pkg::RegToLen,     6'd0,  8'd0,  ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h61, ExpPredict, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h62, ExpPredict, 8'h00},
    // short to-set: squash run, then a copy ends it
    '{RowCfg,  cts_pkg::RegToLen,     6'd0,  8'd1,  ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h00, ExpPredict, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h61, ExpPredict, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h62, ExpPredict, 8'h00},
    // negate: members copy, outsiders squash
    '{RowCfg,  cts_pkg::RegNegate,    6'd0,  8'd1,  ExpNone, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h61, ExpPredict, 8'h00},
    '{RowItem, cts_pkg::ModeData,     6'd0,  8'h70, ExpPredict, 8'h00}
  };

  // Clock, reset and block ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode_in = '0;
  logic [5:0]  index_in = '0;
  logic [7:0]  byte_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [7:0]  from_set [cts_pkg::SetSize];
  logic [7:0]  to_set [cts_pkg::SetSize];
  bit          squash_active = 1'b0;
  bit          cfg_negate = 1'b0;
  logic [6:0]  cfg_from_len = '0;
  logic [6:0]  cfg_to_len = '0;

  logic [7:0]  expected_bytes [$];

  int errors = 0;
  int cycles = 0;
  int n_data = 0;
  int n_loads = 0;
  int n_ignored = 0;
  int n_checked = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_seq = 0;

  char_transliterate_squash_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode_in),
    .entry_index_i (index_in),
    .byte_value_i  (byte_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int clamp_set(input logic [6:0] n);
    return (n > cts_pkg::SetSize) ? int'(cts_pkg::SetSize) : int'(n);
  endfunction

  // Predict the output of one word and advance the table and squash state
  function automatic bit translate_word(input logic [1:0] mode, input logic [5:0] idx,
                                        input logic [7:0] b, output logic [7:0] res);
    int fl;
    int tl;
    int pos;
    bit squash_on;
    res = '0;
    if (mode == cts_pkg::ModeLoadFrom) begin
      from_set[idx] = b;
      return 1'b0;
    end
    if (mode == cts_pkg::ModeLoadTo) begin
      to_set[idx] = b;
      return 1'b0;
    end
    if (mode != cts_pkg::ModeData) return 1'b0;
    fl = clamp_set(cfg_from_len);
    tl = clamp_set(cfg_to_len);
    pos = 0;
    for (int k = 0; k < fl; k++) begin
      if (pos == 0 && from_set[k] == b) pos = k + 1;
    end
    if (cfg_negate) pos = (pos != 0) ? 0 : tl + 1;
    squash_on = (fl > tl || cfg_negate) && tl > 0;
    // one replacement byte per run, the rest of the run is dropped
    if (squash_on && pos >= tl) begin
      if (squash_active) return 1'b0;
      squash_active = 1'b1;
      res = to_set[tl-1];
      return 1'b1;
    end
    squash_active = 1'b0;
    if (pos == 0) begin
      res = b;
      return 1'b1;
    end
    if (pos <= tl) begin
      res = to_set[pos-1];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 20) $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  // Offer one word, wait for it to be taken, then record what it should give
  task automatic send_word(input logic [1:0] mode, input logic [5:0] idx,
                           input logic [7:0] b, input exp_kind_e chk, input logic [7:0] want);
    logic [7:0] res;
    bit has;
    int gap;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    mode_in  = mode;
    index_in = idx;
    byte_in  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = translate_word(mode, idx, b, res);
    if (chk == ExpPredict && has) expected_bytes.push_back(res);
    if (chk == ExpByte) expected_bytes.push_back(want);
    if (mode == cts_pkg::ModeData) n_data++;
    else if (mode == ModeUnused) n_ignored++;
    else n_loads++;
  endtask

  // Stop offering and wait until every expected byte is out
  task automatic drain_outputs();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Let words that give no output finish inside the block
  task automatic quiesce();
    drain_outputs();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] which, input logic [6:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {which, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (which)
      cts_pkg::RegNegate:  cfg_negate = value[0];
      cts_pkg::RegFromLen: cfg_from_len = value;
      cts_pkg::RegToLen:   cfg_to_len = value;
      default: ;
    endcase
  endtask

  function automatic logic [6:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 7'($urandom_range(0, 12));
    if (r < 90) return 7'($urandom_range(13, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  // Data byte: mostly a live from-set member, otherwise anything
  function automatic logic [7:0] data_byte();
    int fl;
    fl = clamp_set(cfg_from_len);
    if (fl > 0 && $urandom_range(99) < 65) return from_set[$urandom_range(fl - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Byte at or beyond the last to-set position, to build squash runs
  function automatic logic [7:0] tail_byte();
    int fl;
    int lo;
    fl = clamp_set(cfg_from_len);
    lo = (clamp_set(cfg_to_len) > 0) ? clamp_set(cfg_to_len) - 1 : 0;
    if (!cfg_negate && fl > lo) return from_set[$urandom_range(lo, fl - 1)];
    return 8'($urandom_range(255));
  endfunction

  task automatic random_phase(input int n_words);
    int sent;
    int r;
    int run_len;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(99);
      if (r < 14) begin
        send_word($urandom_range(1) ? cts_pkg::ModeLoadTo : cts_pkg::ModeLoadFrom,
                  6'($urandom_range(63)), 8'($urandom_range(255)), ExpPredict, 8'h00);
        sent++;
      end else if (r < 17) begin
        send_word(ModeUnused, 6'($urandom_range(63)), 8'($urandom_range(255)),
                  ExpPredict, 8'h00);
      end else if (r < 35) begin
        run_len = $urandom_range(2, 6);
        repeat (run_len) send_word(cts_pkg::ModeData, 6'($urandom_range(63)), tail_byte(),
                                   ExpPredict, 8'h00);
        sent += run_len;
      end else begin
        send_word(cts_pkg::ModeData, 6'($urandom_range(63)), data_byte(), ExpPredict,
                  8'h00);
        sent++;
      end
    end
  endtask

  // Output side: stall in bursts, plus one long hold on request
  int hold_seen = 0;
  int hold_left = 0;
  int burst_left = 0;
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall = 1'b1;
      burst_left--;
    end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      out_stall = 1'b1;
      burst_left = $urandom_range(1, 14) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each taken output word with the oldest expectation
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("output word 0x%h with nothing expected", out_byte));
      end else begin
        want = expected_bytes.pop_front();
        n_checked++;
        if (out_byte !== want)
          report_mismatch($sformatf("out_byte 0x%h, expected 0x%h", out_byte, want));
      end
    end
  end

  // Stimulus
  initial begin
    logic [6:0] fl;
    logic [6:0] tl;
    bit neg;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    for (int i = 0; i < NumRows; i++) begin
      if (dir_rows[i].kind == RowCfg) begin
        quiesce();
        write_reg(dir_rows[i].sel, dir_rows[i].val[6:0]);
      end else begin
        send_word(dir_rows[i].sel, dir_rows[i].idx, dir_rows[i].val,
                  dir_rows[i].chk, dir_rows[i].want);
      end
    end

    // fill both tables so any length can be used
    for (int k = 0; k < cts_pkg::SetSize; k++) begin
      send_word(cts_pkg::ModeLoadFrom, 6'(k), 8'($urandom_range(255)), ExpPredict, 8'h00);
      send_word(cts_pkg::ModeLoadTo, 6'(k), 8'($urandom_range(255)), ExpPredict, 8'h00);
    end

    // register phases: fixed extremes first, then random settings
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin neg = 1'b0; fl = 7'd64;  tl = 7'd64;  end
        1: begin neg = 1'b1; fl = 7'd64;  tl = 7'd64;  end
        2: begin neg = 1'b0; fl = 7'd64;  tl = 7'd1;   end
        3: begin neg = 1'b1; fl = 7'd127; tl = 7'd127; end
        4: begin neg = 1'b0; fl = 7'd8;   tl = 7'd3;   end
        5: begin neg = 1'b1; fl = 7'd5;   tl = 7'd0;   end
        6: begin neg = 1'b0; fl = 7'd3;   tl = 7'd9;   end
        default: begin
          neg = 1'($urandom_range(1));
          fl = pick_len();
          tl = pick_len();
        end
      endcase
      quiesce();
      write_reg(cts_pkg::RegNegate, 7'(neg));
      write_reg(cts_pkg::RegFromLen, fl);
      write_reg(cts_pkg::RegToLen, tl);
      if (p >= NumPhases - 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(2) == 0) ? 0 : 5 + 25 * $urandom_range(1);
        rx_idle_pct = ($urandom_range(2) == 0) ? 0 : 5 + 25 * $urandom_range(1);
      end
      if (p == 4) begin
        // sender pauses midway until all output is back
        random_phase(PhaseWords / 2);
        drain_outputs();
        random_phase(PhaseWords / 2);
      end else if (p == 5) begin
        // long receiver hold while words keep coming
        tx_idle_pct = 0;
        hold_seq++;
        random_phase(PhaseWords);
      end else begin
        random_phase(PhaseWords);
      end
    end

    drain_outputs();
    repeat (SettleCycles) @(posedge clk);
    $display("Run covered %0d data words, %0d table loads and %0d unused-mode words.",
             n_data, n_loads, n_ignored);
    $display("%0d output words compared over %0d register settings, errors: %0d.",
             n_checked, NumPhases, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- char_transliterate_squash_top.f -----
+incdir+rtl
rtl/cts_pkg.sv
rtl/char_transliterate_squash_top.sv
sim/tb.sv
